// ===== rtl/core/kdlp_pkg.sv =====
// Package for the key debounce and long-press unit.
// Holds widths, reset values, register indexes and shared types.
// No dependencies.
`default_nettype none

package kdlp_pkg;

   localparam int KEY_W      = 3;
   localparam int SETTLE_W   = 8;
   localparam int PRESS_W    = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RESET     = 8'd50;
   localparam logic [PRESS_W-1:0]  LONG_PRESS_TICKS_RESET = 16'd700;
   localparam logic [PRESS_W-1:0]  LONG_LIMIT_MAX         = 16'd65533;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETTLE_TICKS     = 8'd0,
      CSR_LONG_PRESS_TICKS = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic [SETTLE_W-1:0] settle_ticks;
      logic [PRESS_W-1:0]  long_press_ticks;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/kdlp_if.sv =====
// Channel interfaces for the key debounce and long-press unit.
// Request, response and register write channels; depends on kdlp_pkg.
`default_nettype none

interface kdlp_req_if;
   logic                      valid;
   logic                      ready;
   logic [kdlp_pkg::KEY_W-1:0] pin_levels;
   modport source (output valid, output pin_levels, input ready);
   modport sink   (input valid, input pin_levels, output ready);
endinterface

interface kdlp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [kdlp_pkg::KEY_W-1:0] event_keys;
   logic                      is_long;
   modport source (output valid, output event_keys, output is_long, input ready);
   modport sink   (input valid, input event_keys, input is_long, output ready);
endinterface

interface kdlp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [kdlp_pkg::CSR_IDX_W-1:0]  index;
   logic [kdlp_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kdlp_csr.sv =====
// Configuration registers of the key debounce and long-press unit.
// Decodes register writes; depends on kdlp_pkg.
`default_nettype none

module kdlp_csr (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            wr_valid,
   output logic                           wr_ready,
   input  wire [kdlp_pkg::CSR_IDX_W-1:0]  wr_index,
   input  wire [kdlp_pkg::CSR_DATA_W-1:0] wr_data,
   output kdlp_pkg::cfg_type              cfg
);

   kdlp_pkg::cfg_type cfg_ff;
   kdlp_pkg::cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (wr_index)
            kdlp_pkg::CSR_SETTLE_TICKS: begin
               cfg_in.settle_ticks = wr_data[kdlp_pkg::SETTLE_W-1:0];
            end
            kdlp_pkg::CSR_LONG_PRESS_TICKS: begin
               cfg_in.long_press_ticks = wr_data[kdlp_pkg::PRESS_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks     <= kdlp_pkg::SETTLE_TICKS_RESET;
         cfg_ff.long_press_ticks <= kdlp_pkg::LONG_PRESS_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/kdlp_core.sv =====
// Sample register, debounce and long-press update, and result register.
// Depends on kdlp_pkg.
`default_nettype none

module kdlp_core (
   input  wire                         clock,
   input  wire                         reset,
   input  kdlp_pkg::cfg_type           cfg,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire [kdlp_pkg::KEY_W-1:0]   in_pins,
   output logic                        out_valid,
   input  wire                         out_ready,
   output logic [kdlp_pkg::KEY_W-1:0]  out_keys,
   output logic                        out_long
);

   logic                              s1_valid_ff, s1_valid_in;
   logic [kdlp_pkg::KEY_W-1:0]        s1_pins_ff;
   logic                              out_valid_ff, out_valid_in;
   logic [kdlp_pkg::KEY_W-1:0]        out_keys_ff, out_keys_in;
   logic                              out_long_ff, out_long_in;
   logic [kdlp_pkg::KEY_W-1:0]        held_ff, held_in;
   logic [kdlp_pkg::SETTLE_W-1:0]     settle_ff, settle_in;
   logic [kdlp_pkg::PRESS_W-1:0]      press_ff, press_in;

   logic                              advance;
   logic [kdlp_pkg::KEY_W-1:0]        keys;
   logic [kdlp_pkg::PRESS_W-1:0]      limit;
   logic [kdlp_pkg::KEY_W-1:0]        ev_keys;
   logic                              ev_long;

   assign advance   = s1_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready  = !s1_valid_ff || advance;
   assign out_valid = out_valid_ff;
   assign out_keys  = out_keys_ff;
   assign out_long  = out_long_ff;

   always_comb begin
      keys    = ~s1_pins_ff;
      limit   = (cfg.long_press_ticks > kdlp_pkg::LONG_LIMIT_MAX) ?
                kdlp_pkg::LONG_LIMIT_MAX : cfg.long_press_ticks;
      held_in   = held_ff;
      settle_in = settle_ff;
      press_in  = press_ff;
      ev_keys   = '0;
      ev_long   = 1'b0;
      if (keys == '0) begin
         held_in = '0;
      end else if (keys != held_ff) begin
         held_in   = keys;
         settle_in = cfg.settle_ticks;
         press_in  = '0;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else if (press_ff == '0) begin
         press_in = kdlp_pkg::PRESS_W'(1);
         ev_keys  = keys;
      end else if (press_ff > limit) begin
         if (press_ff == limit + 1'b1) begin
            press_in = press_ff + 1'b1;
            ev_keys  = keys;
            ev_long  = 1'b1;
         end
      end else begin
         press_in = press_ff + 1'b1;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      out_keys_in  = out_keys_ff;
      out_long_in  = out_long_ff;
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_keys_in  = ev_keys;
         out_long_in  = ev_long;
         s1_valid_in  = 1'b0;
      end
      if (in_valid && in_ready) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_ff      <= '0;
         settle_ff    <= '0;
         press_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            held_ff   <= held_in;
            settle_ff <= settle_in;
            press_ff  <= press_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_pins_ff <= in_pins;
      end
      out_keys_ff <= out_keys_in;
      out_long_ff <= out_long_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/key_debounce_long_press_unit.sv =====
// Top level of the key debounce and long-press unit.
// Depends on kdlp_pkg, kdlp_if, kdlp_csr and kdlp_core.
//
// Each request transfer is one sample tick of three active-low key pins and
// yields exactly one response: the pressed-key mask of a press or long-press
// event, or zero when the tick raises no event. One tick is taken per clock
// cycle unless the response stalls; a sample is registered on transfer and
// its response is registered once the result register is free. Registers
// settle_ticks (index 0) and long_press_ticks (index 1, saturated to 65533)
// are written through the csr channel, which is always ready; write them
// only while no response is pending.
`default_nettype none

module key_debounce_long_press_unit (
   input  wire         clock,
   input  wire         reset,
   kdlp_req_if.sink    req,
   kdlp_rsp_if.source  rsp,
   kdlp_csr_if.sink    csr
);

   kdlp_pkg::cfg_type cfg;

   kdlp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr.valid),
      .wr_ready (csr.ready),
      .wr_index (csr.index),
      .wr_data  (csr.data),
      .cfg      (cfg)
   );

   kdlp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_pins   (req.pin_levels),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_keys  (rsp.event_keys),
      .out_long  (rsp.is_long)
   );

endmodule

`default_nettype wire

// ===== rtl/core/kdlp_checker.sv =====
// Port-level checks for the key debounce and long-press unit.
// Bound to key_debounce_long_press_unit; depends on kdlp_pkg.
`default_nettype none

module kdlp_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input wire [kdlp_pkg::KEY_W-1:0]  rsp_event_keys,
   input wire                        rsp_is_long
);

   a_long_has_keys: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_long) |-> (rsp_event_keys != '0))
      else $error("long-press event without keys");

   a_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_event_keys) && $stable(rsp_is_long)))
      else $error("stalled response changed");

endmodule

bind key_debounce_long_press_unit kdlp_checker u_kdlp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_event_keys (rsp.event_keys),
   .rsp_is_long    (rsp.is_long)
);

`default_nettype wire
